// ===== src/ewt_pkg.sv =====
// ewt_pkg: shared types and constants of the escaped word tokenizer
// used by ewt_ctrl, ewt_dp and escaped_word_tokenizer_core; no dependencies
`default_nettype none

package ewt_pkg;

  // character codes
  localparam logic [7:0] CHAR_BSLASH = 8'd92;
  localparam logic [7:0] CHAR_N      = 8'd110;
  localparam logic [7:0] CHAR_T      = 8'd116;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_TAB    = 8'd9;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_SPACE  = 8'd32;

  // result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_WEND = 2'd1;
  localparam logic [1:0] KIND_EOS  = 2'd2;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] REG_SEP_MAP_0    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SEP_MAP_1    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SEP_MAP_2    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SEP_MAP_3    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COMMENT_CODE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_WORD_LIMIT   = 3'd5;

  localparam int unsigned WordLenW = 12;
  localparam logic [WordLenW-1:0] WORD_LIMIT_RST = 12'd255;

  // what an accepted item asks of the output side
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EOS,
    ACT_WEND_EOS,
    ACT_WEND,
    ACT_CHAR,
    ACT_FLUSH
  } act_e;

  // source of the next result loaded into the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_WEND,
    EMIT_EOS,
    EMIT_CHAR,
    EMIT_HELD,
    EMIT_SPACE
  } emit_e;

  typedef struct packed {
    logic  accept;
    emit_e emit;
    logic  emit_last;
    logic  rd_en;
    logic  idx_clr;
    logic  idx_inc;
    logic  flush_done;
  } dp_cmd_t;

  typedef struct packed {
    act_e act;
    logic out_free;
    logic flush_more;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/ewt_ram.sv =====
// ewt_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ewt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/ewt_ctrl.sv =====
// ewt_ctrl: sequencer of the tokenizer; takes items and orders the results
// depends on ewt_pkg
`default_nettype none

module ewt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  input  wire ewt_pkg::dp_status_t status_i,
  output ewt_pkg::dp_cmd_t         cmd_o
);
  import ewt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FLUSH,
    S_HELD,
    S_EOS
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    s_ready_o       = 1'b0;
    cmd_o           = '0;
    cmd_o.emit      = EMIT_NONE;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o    = status_i.out_free;
        cmd_o.accept = s_valid_i && status_i.out_free;
        if (cmd_o.accept) begin
          unique case (status_i.act)
            ACT_NONE: begin
            end
            ACT_EOS: begin
              cmd_o.emit      = EMIT_EOS;
              cmd_o.emit_last = 1'b1;
            end
            ACT_WEND_EOS: begin
              cmd_o.emit = EMIT_WEND;
              state_d    = S_EOS;
            end
            ACT_WEND: begin
              cmd_o.emit      = EMIT_WEND;
              cmd_o.emit_last = 1'b1;
            end
            ACT_CHAR: begin
              cmd_o.emit      = EMIT_CHAR;
              cmd_o.emit_last = 1'b1;
            end
            ACT_FLUSH: begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.idx_clr = 1'b1;
              state_d       = S_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.emit = EMIT_SPACE;
          if (status_i.flush_more) begin
            cmd_o.idx_inc = 1'b1;
            cmd_o.rd_en   = 1'b1;
          end else begin
            state_d = S_HELD;
          end
        end
      end
      S_HELD: begin
        if (status_i.out_free) begin
          cmd_o.emit       = EMIT_HELD;
          cmd_o.emit_last  = 1'b1;
          cmd_o.flush_done = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_EOS: begin
        if (status_i.out_free) begin
          cmd_o.emit      = EMIT_EOS;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ewt_dp.sv =====
// ewt_dp: tokenizer datapath; config registers, word state, held whitespace
// store and the output register; depends on ewt_pkg and ewt_ram
`default_nettype none

module ewt_dp #(
  parameter int unsigned SPACE_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ewt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ewt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic [7:0]                    in_char_i,
  input  wire logic                          string_end_i,
  input  wire ewt_pkg::dp_cmd_t              cmd_i,
  output ewt_pkg::dp_status_t                status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         out_kind_o,
  output logic [7:0]                         out_char_o,
  output logic                               out_empty_o,
  output logic                               out_ovf_o,
  output logic                               out_last_o
);
  import ewt_pkg::*;

  localparam int unsigned AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SPACE_DEPTH + 1);
  localparam logic [CW-1:0] CountMax = CW'(SPACE_DEPTH);

  // configuration
  logic [255:0]          sep_map_q;
  logic [7:0]            comment_q;
  logic [WordLenW-1:0]   limit_q;

  // word state
  logic                  esc_q, esc_d;
  logic                  cmt_q, cmt_d;
  logic [WordLenW-1:0]   wlen_q, wlen_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic                  text_q, text_d;
  logic [7:0]            held_q;
  logic [AW-1:0]         idx_q, idx_d;

  // output register
  logic                  ov_q;
  logic [1:0]            okind_q;
  logic [7:0]            ochar_q;
  logic                  oempty_q, oovf_q, olast_q;

  // decode of the incoming item
  logic [7:0] c_eff;
  logic       is_sep, is_cmt, is_bs, at_limit, is_white, wr_en;
  logic [7:0] rdata;
  act_e       act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_map_q <= '0;
      comment_q <= '0;
      limit_q   <= WORD_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SEP_MAP_0:    sep_map_q[63:0]    <= cfg_data_i;
        REG_SEP_MAP_1:    sep_map_q[127:64]  <= cfg_data_i;
        REG_SEP_MAP_2:    sep_map_q[191:128] <= cfg_data_i;
        REG_SEP_MAP_3:    sep_map_q[255:192] <= cfg_data_i;
        REG_COMMENT_CODE: comment_q          <= cfg_data_i[7:0];
        REG_WORD_LIMIT:   limit_q            <= cfg_data_i[WordLenW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    c_eff = in_char_i;
    if (esc_q && in_char_i == CHAR_N) begin
      c_eff = CHAR_LF;
    end else if (esc_q && in_char_i == CHAR_T) begin
      c_eff = CHAR_TAB;
    end
  end

  assign is_sep   = !esc_q && sep_map_q[in_char_i];
  assign is_cmt   = !esc_q && (comment_q != 8'd0) && (in_char_i == comment_q);
  assign is_bs    = !esc_q && (in_char_i == CHAR_BSLASH);
  assign at_limit = wlen_q >= limit_q;
  assign is_white = (c_eff == CHAR_SPACE) || ((c_eff >= CHAR_TAB) && (c_eff <= CHAR_CR));

  always_comb begin
    priority if (string_end_i) begin
      act = (!cmt_q && wlen_q != '0) ? ACT_WEND_EOS : ACT_EOS;
    end else if (cmt_q) begin
      act = ACT_NONE;
    end else if (is_sep) begin
      act = ACT_WEND;
    end else if (is_cmt) begin
      act = (wlen_q != '0) ? ACT_WEND : ACT_NONE;
    end else if (is_bs) begin
      act = ACT_NONE;
    end else if (at_limit) begin
      act = ACT_WEND;
    end else if (is_white) begin
      act = ACT_NONE;
    end else begin
      act = (cnt_q != '0) ? ACT_FLUSH : ACT_CHAR;
    end
  end

  // state update for an accepted item, and the held count cleared at the end of a flush
  always_comb begin
    esc_d  = esc_q;
    cmt_d  = cmt_q;
    wlen_d = wlen_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    text_d = text_q;
    wr_en  = 1'b0;
    if (cmd_i.flush_done) begin
      cnt_d = '0;
    end
    if (cmd_i.accept) begin
      priority if (string_end_i || (!cmt_q && (is_sep || is_cmt || (!is_bs && at_limit)))) begin
        esc_d  = 1'b0;
        wlen_d = '0;
        cnt_d  = '0;
        ovf_d  = 1'b0;
        text_d = 1'b0;
        cmt_d  = !string_end_i && is_cmt && !is_sep;
      end else if (cmt_q) begin
      end else if (is_bs) begin
        esc_d = 1'b1;
      end else begin
        esc_d  = 1'b0;
        wlen_d = wlen_q + 1'b1;
        if (is_white) begin
          if (cnt_q < CountMax) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          text_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      cmt_q  <= 1'b0;
      wlen_q <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      text_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      esc_q  <= esc_d;
      cmt_q  <= cmt_d;
      wlen_q <= wlen_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      text_q <= text_d;
      idx_q  <= idx_d;
    end
  end

  // character waiting behind the held whitespace
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      held_q <= c_eff;
    end
  end

  ewt_ram #(
    .WIDTH (8),
    .DEPTH (SPACE_DEPTH)
  ) u_space_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (c_eff),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit != EMIT_NONE) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EMIT_NONE) begin
      olast_q  <= cmd_i.emit_last;
      okind_q  <= KIND_CHAR;
      ochar_q  <= 8'd0;
      oempty_q <= 1'b0;
      oovf_q   <= 1'b0;
      unique case (cmd_i.emit)
        EMIT_WEND: begin
          okind_q  <= KIND_WEND;
          oempty_q <= !text_q;
          oovf_q   <= ovf_q;
        end
        EMIT_EOS:   okind_q <= KIND_EOS;
        EMIT_CHAR:  ochar_q <= c_eff;
        EMIT_HELD:  ochar_q <= held_q;
        EMIT_SPACE: ochar_q <= rdata;
        default: begin
        end
      endcase
    end
  end

  assign status_o.act        = act;
  assign status_o.out_free   = !ov_q || out_ready_i;
  assign status_o.flush_more = (CW'(idx_q) + 1'b1) < cnt_q;

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_char_o  = ochar_q;
  assign out_empty_o = oempty_q;
  assign out_ovf_o   = oovf_q;
  assign out_last_o  = olast_q;

endmodule

`default_nettype wire

// ===== src/escaped_word_tokenizer_core.sv =====
// a result sits in the output register in the cycle after the item that caused it;
//   an item that releases held whitespace reads the ram first, and its first result
//   comes from S_FLUSH once the output register is free
// throughput: one item per cycle while an item gives at most one result; items that give
//   more (held whitespace, one ram read per space, then the waiting character; a string
//   end closing a word) block the input until done; a stalled receiver stalls the input
// reset: control state and configuration return to defaults at once; the whitespace
//   store keeps no reset and needs no clearing pass
`default_nettype none

module escaped_word_tokenizer_core #(
  parameter int unsigned SPACE_DEPTH = 32  // held whitespace entries, 1 to 63
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ewt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ewt_pkg::CfgDataW-1:0]  cfg_data_i,
  // character items in
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] in_char
  input  wire logic                          s_axis_tlast,   // string_end
  // result items out
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [15:0]                        m_axis_tdata,   // [7:0] out_char,
                                                             // [8] word_empty,
                                                             // [9] space_overflow
  output logic [1:0]                         m_axis_tuser,   // [1:0] kind
  output logic                               m_axis_tlast    // run_last
);
  import ewt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [7:0] out_char;
  logic       out_empty, out_ovf;

  // always taken; the user writes the configuration only while idle, the block does not check
  assign cfg_ready_o = 1'b1;

  // sequencer: accepts items, then walks held whitespace out before the waiting character
  ewt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // datapath: decode of each character, word state, whitespace ram, output register
  ewt_dp #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_char_i    (s_axis_tdata),
    .string_end_i (s_axis_tlast),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_char_o   (out_char),
    .out_empty_o  (out_empty),
    .out_ovf_o    (out_ovf),
    .out_last_o   (m_axis_tlast)
  );

  // pack result fields, lowest field first, zero filled to two bytes
  assign m_axis_tdata = {6'd0, out_ovf, out_empty, out_char};

endmodule

`default_nettype wire

// ===== tb/ewt_checker.sv =====
// ewt_checker: watches the configuration, character and result channels of the
// escaped word tokenizer, predicts every result and compares it field by field
// depends on ewt_pkg for result kinds, character codes and register indexes
`default_nettype none

module ewt_checker #(
  parameter int unsigned SPACE_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_i,
  input  wire logic [ewt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ewt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [7:0]                    in_data_i,
  input  wire logic                          in_last_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [15:0]                   out_data_i,
  input  wire logic [1:0]                    out_user_i,
  input  wire logic                          out_last_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ewt_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       empty;
    logic       ovf;
    logic       last;
  } token_t;

  // configuration copy
  logic [255:0]         sep_map;
  logic [7:0]           cmt_code;
  logic [WordLenW-1:0]  word_limit;

  // tokenizer state
  logic                 esc_pend;
  logic                 in_comment;
  logic [WordLenW-1:0]  word_len;
  logic [7:0]           held_ws [SPACE_DEPTH];
  int unsigned          held_cnt;
  logic                 ws_dropped;
  logic                 has_text;

  token_t expected_tokens [$];
  int     fails = 0;
  int     outstanding = 0;

  assign fail_count_o = fails;
  assign pending_o    = outstanding;

  function automatic token_t word_end_token();
    word_end_token = '{kind: KIND_WEND, ch: 8'd0, empty: !has_text, ovf: ws_dropped,
                       last: 1'b0};
  endfunction

  function automatic token_t char_token(input logic [7:0] c);
    char_token = '{kind: KIND_CHAR, ch: c, empty: 1'b0, ovf: 1'b0, last: 1'b0};
  endfunction

  task automatic clear_word();
    word_len   = '0;
    held_cnt   = 0;
    ws_dropped = 1'b0;
    has_text   = 1'b0;
    esc_pend   = 1'b0;
  endtask

  // results of one character item, run_last set on the final one
  task automatic tokenize_item(input logic [7:0] code, input logic eos);
    token_t     run [$];
    logic [7:0] c;
    c = code;
    if (eos) begin
      if (!in_comment && word_len != 0) run.push_back(word_end_token());
      run.push_back('{kind: KIND_EOS, ch: 8'd0, empty: 1'b0, ovf: 1'b0, last: 1'b0});
      clear_word();
      in_comment = 1'b0;
    end else if (in_comment) begin
      // everything ignored until string end
    end else if (!esc_pend && sep_map[c]) begin
      run.push_back(word_end_token());
      clear_word();
    end else if (!esc_pend && cmt_code != 8'd0 && c == cmt_code) begin
      if (word_len != 0) run.push_back(word_end_token());
      clear_word();
      in_comment = 1'b1;
    end else if (!esc_pend && c == CHAR_BSLASH) begin
      esc_pend = 1'b1;
    end else if (word_len >= word_limit) begin
      // character at the limit is dropped
      run.push_back(word_end_token());
      clear_word();
    end else begin
      if (esc_pend) begin
        if (c == CHAR_N) c = CHAR_LF;
        else if (c == CHAR_T) c = CHAR_TAB;
        esc_pend = 1'b0;
      end
      word_len = word_len + 1'b1;
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
        if (held_cnt < SPACE_DEPTH) begin
          held_ws[held_cnt] = c;
          held_cnt++;
        end else begin
          ws_dropped = 1'b1;
        end
      end else begin
        for (int i = 0; i < held_cnt; i++) run.push_back(char_token(held_ws[i]));
        held_cnt = 0;
        run.push_back(char_token(c));
        has_text = 1'b1;
      end
    end
    if (run.size() != 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_tokens.push_back(run[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_t got;
    token_t want;
    if (!rst_ni) begin
      sep_map      = '0;
      cmt_code     = 8'd0;
      word_limit   = WORD_LIMIT_RST;
      in_comment   = 1'b0;
      clear_word();
      expected_tokens.delete();
    end else begin
      // results first: nothing accepted at this edge can already be on the output
      if (out_valid_i && out_ready_i) begin
        got = '{kind: out_user_i, ch: out_data_i[7:0], empty: out_data_i[8],
                ovf: out_data_i[9], last: out_last_i};
        if (expected_tokens.size() == 0) begin
          $error("result with nothing expected: kind %0d char %0d", got.kind, got.ch);
          fails++;
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fails++;
          end
          if (got.ch != want.ch) begin
            $error("out_char: expected %0d, got %0d", want.ch, got.ch);
            fails++;
          end
          if (got.empty != want.empty) begin
            $error("word_empty: expected %0d, got %0d", want.empty, got.empty);
            fails++;
          end
          if (got.ovf != want.ovf) begin
            $error("space_overflow: expected %0d, got %0d", want.ovf, got.ovf);
            fails++;
          end
          if (got.last != want.last) begin
            $error("run_last: expected %0d, got %0d", want.last, got.last);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SEP_MAP_0:    sep_map[63:0]    = cfg_data_i;
          REG_SEP_MAP_1:    sep_map[127:64]  = cfg_data_i;
          REG_SEP_MAP_2:    sep_map[191:128] = cfg_data_i;
          REG_SEP_MAP_3:    sep_map[255:192] = cfg_data_i;
          REG_COMMENT_CODE: cmt_code         = cfg_data_i[7:0];
          REG_WORD_LIMIT:   word_limit       = cfg_data_i[WordLenW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) tokenize_item(in_data_i, in_last_i);
    end
    outstanding = expected_tokens.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb_escaped_word_tokenizer_core.sv =====
// tb_escaped_word_tokenizer_core: stimulus and verdict for escaped_word_tokenizer_core
// drives configuration and character items, leaves prediction and checking to ewt_checker
// depends on ewt_pkg, ewt_checker and the tokenizer rtl
`default_nettype none

module tb_escaped_word_tokenizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ewt_pkg::*;

  localparam int unsigned SPACE_DEPTH = 32;
  // worst case ~350 items x 33 results, slowed by stall and flush, taken four times
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // margin after the last result before the configuration changes
  localparam int unsigned SETTLE_CYCLES = 5;
  localparam int unsigned DIRECTED_N = 27;

  // bit 8 set marks a string end item
  localparam logic [8:0] EOS_ITEM = 9'h100;

  localparam logic [7:0] CHAR_HASH  = 8'd35;
  localparam logic [7:0] CHAR_COMMA = 8'd44;
  localparam logic [7:0] CHAR_SEMI  = 8'd59;
  localparam logic [7:0] CHAR_BAR   = 8'd124;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = REG_SEP_MAP_0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data = 8'd0;
  logic                 in_last = 1'b0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [15:0]          out_data;
  logic [1:0]           out_user;
  logic                 out_last;

  int                   fail_count;
  int                   pending;
  int unsigned          cycle_count = 0;

  // idle percentages of the character sender and the result receiver
  int unsigned          src_idle_pct = 12;
  int unsigned          snk_idle_pct = 67;

  // comment character of the active setting, used by the random text
  logic [7:0]           cur_comment = 8'd0;

  // directed sequence, separators comma, semicolon and 0xff, comment hash, limit 4
  logic [8:0] directed_items [DIRECTED_N] = '{
    9'("a"), 9'(CHAR_SPACE), 9'("b"),             // held space let through
    9'(CHAR_SPACE), 9'(CHAR_COMMA),                // trailing space dropped at word end
    9'(CHAR_COMMA),                                // empty word between separators
    9'(CHAR_SPACE), 9'(CHAR_SEMI),                 // word of only whitespace
    9'(CHAR_BSLASH), 9'(CHAR_N),                   // escaped n held as newline
    9'(CHAR_BSLASH), 9'(CHAR_COMMA),               // escaped separator is literal
    9'(CHAR_BSLASH), 9'(CHAR_BSLASH),              // escaped backslash
    9'("z"),                                       // word now at the limit
    9'(CHAR_BSLASH), 9'("q"),                      // limit hit with escape pending
    9'h0ff,                                        // top code as separator, escape gone
    9'h000,                                        // code zero as a word character
    9'(CHAR_BSLASH), 9'(CHAR_T),                   // escaped t held as tab
    9'(CHAR_HASH),                                 // comment ends the word
    EOS_ITEM,                                      // string end inside a comment
    9'(CHAR_HASH), EOS_ITEM,                       // comment with empty word
    9'("k"), EOS_ITEM                              // string end closes a word
  };

  escaped_word_tokenizer_core #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tlast  (in_last),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .m_axis_tuser  (out_user),
    .m_axis_tlast  (out_last)
  );

  ewt_checker #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .in_last_i    (in_last),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .out_user_i   (out_user),
    .out_last_i   (out_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls at random, changes only at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // called at a falling edge; valid stays high when the next item follows at once
  task automatic send_item(input logic [7:0] data, input logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= data;
    in_last  <= eos;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // writes every register, only while the block is idle
  task automatic set_config(input logic [63:0] map0, input logic [63:0] map1,
                            input logic [63:0] map2, input logic [63:0] map3,
                            input logic [7:0] comment, input logic [WordLenW-1:0] limit);
    write_reg(REG_SEP_MAP_0, map0);
    write_reg(REG_SEP_MAP_1, map1);
    write_reg(REG_SEP_MAP_2, map2);
    write_reg(REG_SEP_MAP_3, map3);
    write_reg(REG_COMMENT_CODE, 64'(comment));
    write_reg(REG_WORD_LIMIT, 64'(limit));
    cfg_valid   <= 1'b0;
    cur_comment = comment;
  endtask

  // all expected results in, then a short margin
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [63:0] sparse_bits();
    sparse_bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] blank_char();
    blank_char = ($urandom_range(2) == 0) ? 8'(9 + $urandom_range(4)) : CHAR_SPACE;
  endfunction

  // mostly word text with spaces, escapes, separators and comments; some raw noise
  task automatic send_random_text(input int n);
    int left;
    int pick;
    int burst;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_item(8'("a" + $urandom_range(25)), 1'b0);
        left--;
      end else if (pick < 55) begin
        send_item(blank_char(), 1'b0);
        left--;
      end else if (pick < 58) begin
        // long whitespace run, mostly enough to fill the held store
        burst = $urandom_range(30, 40);
        repeat (burst) send_item(blank_char(), 1'b0);
        send_item(8'("a" + $urandom_range(25)), 1'b0);
        left -= burst + 1;
      end else if (pick < 66) begin
        case ($urandom_range(2))
          0: send_item(CHAR_COMMA, 1'b0);
          1: send_item(CHAR_SEMI, 1'b0);
          default: send_item(CHAR_BAR, 1'b0);
        endcase
        left--;
      end else if (pick < 70) begin
        send_item(cur_comment, 1'b0);
        left--;
      end else if (pick < 78) begin
        send_item(CHAR_BSLASH, 1'b0);
        case ($urandom_range(3))
          0: send_item(CHAR_N, 1'b0);
          1: send_item(CHAR_T, 1'b0);
          default: send_item(8'($urandom_range(255)), 1'b0);
        endcase
        left -= 2;
      end else if (pick < 84) begin
        send_item(8'($urandom_range(255)), 1'b1);
        left--;
      end else begin
        send_item(8'($urandom_range(255)), 1'b0);
        left--;
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part: sender idles lightly, receiver heavily
    set_config((64'd1 << CHAR_COMMA) | (64'd1 << CHAR_SEMI), 64'd0, 64'd0,
               64'd1 << 63, CHAR_HASH, 12'd4);
    foreach (directed_items[k]) begin
      send_item(directed_items[k][8] ? 8'($urandom_range(255)) : directed_items[k][7:0],
                directed_items[k][8]);
    end
    wait_idle();

    // usual separators, reset limit, sparse high-code separators
    set_config((64'd1 << CHAR_COMMA) | (64'd1 << CHAR_SEMI), 64'd1 << (CHAR_BAR - 64),
               sparse_bits(), sparse_bits(), CHAR_HASH, WORD_LIMIT_RST);
    send_random_text(60);
    wait_idle();

    // every code a separator, comments off, widest limit
    set_config('1, '1, '1, '1, 8'd0, 12'd4095);
    send_random_text(20);
    wait_idle();

    // sender idles heavily, receiver lightly
    src_idle_pct = 67;
    snk_idle_pct = 12;

    // no separators, high-code comment, one character per word
    set_config(64'd0, 64'd0, 64'd0, 64'd0, 8'($urandom_range(128, 255)), 12'd1);
    send_random_text(40);
    wait_idle();

    // comment character that is also a separator, so the separator wins
    set_config((64'd1 << CHAR_COMMA) | (64'd1 << CHAR_SEMI), 64'd1 << (CHAR_BAR - 64),
               64'd0, 64'd0, CHAR_SEMI, 12'd5);
    send_random_text(60);
    wait_idle();

    // no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;

    // random sparse separators everywhere, top comment code
    set_config(sparse_bits(), sparse_bits(), sparse_bits(), sparse_bits(), 8'd255, 12'd4095);
    send_random_text(60);
    wait_idle();

    // short random limit so words get cut often
    set_config((64'd1 << CHAR_COMMA) | (64'd1 << CHAR_SEMI), 64'd1 << (CHAR_BAR - 64),
               64'd0, 64'd0, CHAR_HASH, 12'($urandom_range(1, 40)));
    send_random_text(70);
    wait_idle();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/ewt_pkg.sv
src/ewt_ram.sv
src/ewt_ctrl.sv
src/ewt_dp.sv
src/escaped_word_tokenizer_core.sv
tb/ewt_checker.sv
tb/tb_escaped_word_tokenizer_core.sv
